FILE: rtl/core/mwac_pkg.sv
// Shared widths, reset values and register codes of the window average calibrator.
package mwac_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int SUM_W        = 20;
	localparam int GAIN_W       = 32;
	localparam int OFS_W        = 16;
	localparam int READING_W    = 16;
	localparam int CHAN_W       = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int NUM_FIELDS   = 8;
	localparam int PH_CHANNELS  = 4;
	localparam int SCALE_SHIFT  = 24;
	localparam int WINDOW_DEF   = 100;
	localparam int CHANNELS_DEF = 8;

	localparam logic signed [GAIN_W-1:0] PH_GAIN_RST    = -32'sd195722;
	localparam logic signed [OFS_W-1:0]  PH_OFS_RST     = 16'sd3970;
	localparam logic signed [GAIN_W-1:0] MOIST_GAIN_RST = 32'sd1048833;
	localparam logic signed [OFS_W-1:0]  MOIST_OFS_RST  = 16'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PH_GAIN      = 2'd0,
		CFG_PH_OFFSET    = 2'd1,
		CFG_MOIST_GAIN   = 2'd2,
		CFG_MOIST_OFFSET = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		MODE_STORE  = 1'b0,
		MODE_REPORT = 1'b1
	} mode_t;

endpackage

FILE: rtl/core/mwac_if.sv
// Handshake channel interfaces: sample input, result output and register writes.
interface mwac_in_if;
	import mwac_pkg::*;
	logic                valid;
	logic                ready;
	logic                mode;
	logic [SAMPLE_W-1:0] ph_sample_a;
	logic [SAMPLE_W-1:0] ph_sample_b;
	logic [SAMPLE_W-1:0] ph_sample_c;
	logic [SAMPLE_W-1:0] ph_sample_d;
	logic [SAMPLE_W-1:0] wet_sample_a;
	logic [SAMPLE_W-1:0] wet_sample_b;
	logic [SAMPLE_W-1:0] wet_sample_c;
	logic [SAMPLE_W-1:0] wet_sample_d;

	modport source (output valid, mode, ph_sample_a, ph_sample_b, ph_sample_c, ph_sample_d,
		wet_sample_a, wet_sample_b, wet_sample_c, wet_sample_d, input ready);
	modport sink (input valid, mode, ph_sample_a, ph_sample_b, ph_sample_c, ph_sample_d,
		wet_sample_a, wet_sample_b, wet_sample_c, wet_sample_d, output ready);
endinterface

interface mwac_out_if;
	import mwac_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [CHAN_W-1:0]           channel;
	logic signed [READING_W-1:0] reading;
	logic                        last;

	modport source (output valid, channel, reading, last, input ready);
	modport sink (input valid, channel, reading, last, output ready);
endinterface

interface mwac_cfg_if;
	import mwac_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/mwac_lane.sv
// One channel lane: sample ring memory and running window sum.
module mwac_lane #(
	parameter int WINDOW = mwac_pkg::WINDOW_DEF,
	parameter int AW     = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [AW-1:0]                 rd_addr,
	input  logic                          row_vld,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [mwac_pkg::SAMPLE_W-1:0] wr_data,
	output logic [mwac_pkg::SUM_W-1:0]    sum
);
	import mwac_pkg::*;

	logic [SAMPLE_W-1:0] ring [WINDOW];
	logic [SAMPLE_W-1:0] rd_q;
	logic [SAMPLE_W-1:0] last_q;
	logic                vld_q;
	logic                fwd_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] old;

	always_ff @(posedge clk) begin
		rd_q <= ring[rd_addr];
		if (wr_en) begin
			ring[wr_addr] <= wr_data;
			last_q        <= wr_data;
		end
	end

	// A read of the row being written in the same cycle returns stale data,
	// so the sample just written is taken instead.
	always_comb begin
		if (fwd_q) begin
			old = last_q;
		end else if (vld_q) begin
			old = rd_q;
		end else begin
			old = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			fwd_q <= 1'b0;
			sum_q <= '0;
		end else begin
			vld_q <= row_vld;
			fwd_q <= wr_en && (wr_addr == rd_addr);
			if (wr_en) begin
				sum_q <= sum_q - SUM_W'(old) + SUM_W'(wr_data);
			end
		end
	end

	assign sum = sum_q;

endmodule

FILE: rtl/core/mwac_merge.sv
// Report serializer: one shared multiplier scales each window sum, then offset and clamp.
module mwac_merge #(
	parameter int CHANNELS = mwac_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [mwac_pkg::SUM_W-1:0]        sums [CHANNELS],
	input  logic signed [mwac_pkg::GAIN_W-1:0] ph_gain,
	input  logic signed [mwac_pkg::OFS_W-1:0]  ph_offset,
	input  logic signed [mwac_pkg::GAIN_W-1:0] moist_gain,
	input  logic signed [mwac_pkg::OFS_W-1:0]  moist_offset,
	output logic                              can_load,
	mwac_out_if.source                        out_item
);
	import mwac_pkg::*;

	localparam int CW     = $clog2(CHANNELS);
	localparam int PROD_W = SUM_W + 1 + GAIN_W;
	localparam int Q_W    = PROD_W - SCALE_SHIFT;
	localparam int R_W    = Q_W + 1;
	localparam logic signed [R_W-1:0] R_MAX = R_W'(32767);
	localparam logic signed [R_W-1:0] R_MIN = -R_W'(32768);

	logic [SUM_W-1:0]           sum_buf_q [CHANNELS];
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       p_vld_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic [CHAN_W-1:0]          chan_s2;
	logic                       last_s2;
	logic                       o_vld_q;
	logic [CHAN_W-1:0]          o_chan_q;
	logic signed [READING_W-1:0] o_read_q;
	logic                       o_last_q;

	logic                       o_adv;
	logic                       p_adv;
	logic                       iss;
	logic                       iss_last;
	logic [CHAN_W-1:0]          chan_sel;
	logic signed [GAIN_W-1:0]   gain_sel;
	logic signed [SUM_W:0]      sum_sx;
	logic signed [PROD_W-1:0]   prod_nx;
	logic signed [OFS_W-1:0]    ofs_sel;
	logic signed [Q_W-1:0]      q_s2;
	logic signed [R_W-1:0]      r_s2;
	logic signed [READING_W-1:0] read_nx;

	assign o_adv    = !o_vld_q || out_item.ready;
	assign p_adv    = !p_vld_s2 || o_adv;
	assign iss      = busy_q && p_adv;
	assign iss_last = iss && (cnt_q == CW'(CHANNELS - 1));
	assign can_load = !busy_q || iss_last;

	assign chan_sel = CHAN_W'(cnt_q);
	assign gain_sel = (chan_sel < CHAN_W'(PH_CHANNELS)) ? ph_gain : moist_gain;
	assign sum_sx   = signed'({1'b0, sum_buf_q[cnt_q]});
	assign prod_nx  = PROD_W'(sum_sx) * PROD_W'(gain_sel);

	// The arithmetic shift rounds toward minus infinity.
	assign ofs_sel = (chan_s2 < CHAN_W'(PH_CHANNELS)) ? ph_offset : moist_offset;
	assign q_s2    = prod_s2[PROD_W-1:SCALE_SHIFT];
	assign r_s2    = R_W'(q_s2) + R_W'(ofs_sel);

	always_comb begin
		if (r_s2 > R_MAX) begin
			read_nx = READING_W'(R_MAX);
		end else if (r_s2 < R_MIN) begin
			read_nx = READING_W'(R_MIN);
		end else begin
			read_nx = READING_W'(r_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			p_vld_s2 <= 1'b0;
			o_vld_q  <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (iss) begin
				if (iss_last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			if (p_adv) begin
				p_vld_s2 <= iss;
			end
			if (o_adv) begin
				o_vld_q <= p_vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_buf_q <= sums;
		end
		if (iss) begin
			prod_s2 <= prod_nx;
			chan_s2 <= chan_sel;
			last_s2 <= iss_last;
		end
		if (o_adv && p_vld_s2) begin
			o_chan_q <= chan_s2;
			o_read_q <= read_nx;
			o_last_q <= last_s2;
		end
	end

	assign out_item.valid   = o_vld_q;
	assign out_item.channel = o_chan_q;
	assign out_item.reading = o_read_q;
	assign out_item.last    = o_last_q;

endmodule

FILE: rtl/core/multichannel_window_average_calibrate.sv
// Top level of the multichannel window average calibrator.
//
//  Channel   Direction  Carries
//  in_item   sink       mode, four pH samples, four moisture samples
//  out_item  source     channel, reading (signed Q8.8), last
//  cfg       sink       register index and write data (always ready)
//
// A store item is taken every cycle while no report waits in the first stage;
// its samples pass the first stage register into the rings and window sums.
// A report item occupies the shared multiplier in the merge stage while it issues
// one channel after another; the next report can load as its last channel issues.
// After reset the rings read as zero through one valid bit per ring row, so
// there is no clearing pass. A stalled output backs up the merge stage, and
// then a waiting report holds the input stage.
module multichannel_window_average_calibrate #(
	parameter int WINDOW   = mwac_pkg::WINDOW_DEF,
	parameter int CHANNELS = mwac_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mwac_in_if.sink     in_item,
	mwac_out_if.source  out_item,
	mwac_cfg_if.sink    cfg
);
	import mwac_pkg::*;

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic signed [GAIN_W-1:0] ph_gain_q;
	logic signed [OFS_W-1:0]  ph_ofs_q;
	logic signed [GAIN_W-1:0] moist_gain_q;
	logic signed [OFS_W-1:0]  moist_ofs_q;

	logic [SAMPLE_W-1:0] fld [NUM_FIELDS];
	logic [AW-1:0]       pos_q;
	logic [WINDOW-1:0]   row_vld_q;
	logic                s1_vld_q;
	logic                s1_rep_q;
	logic [AW-1:0]       pos_s1;
	logic [SAMPLE_W-1:0] smp_s1 [CHANNELS];
	logic [SUM_W-1:0]    lane_sum [CHANNELS];

	logic in_acc;
	logic s1_adv;
	logic wr_en;
	logic load;
	logic can_load;
	logic row_vld;

	assign fld[0] = in_item.ph_sample_a;
	assign fld[1] = in_item.ph_sample_b;
	assign fld[2] = in_item.ph_sample_c;
	assign fld[3] = in_item.ph_sample_d;
	assign fld[4] = in_item.wet_sample_a;
	assign fld[5] = in_item.wet_sample_b;
	assign fld[6] = in_item.wet_sample_c;
	assign fld[7] = in_item.wet_sample_d;

	// Stores always leave the first stage; a report waits for the merge stage.
	assign s1_adv        = !s1_rep_q || can_load;
	assign in_item.ready = !s1_vld_q || s1_adv;
	assign in_acc        = in_item.valid && in_item.ready;
	assign wr_en         = s1_vld_q && !s1_rep_q;
	assign load          = s1_vld_q && s1_rep_q && can_load;
	assign row_vld       = row_vld_q[pos_q];
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_gain_q    <= PH_GAIN_RST;
			ph_ofs_q     <= PH_OFS_RST;
			moist_gain_q <= MOIST_GAIN_RST;
			moist_ofs_q  <= MOIST_OFS_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_PH_GAIN:      ph_gain_q    <= GAIN_W'(cfg.data);
				CFG_PH_OFFSET:    ph_ofs_q     <= cfg.data[OFS_W-1:0];
				CFG_MOIST_GAIN:   moist_gain_q <= GAIN_W'(cfg.data);
				CFG_MOIST_OFFSET: moist_ofs_q  <= cfg.data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			row_vld_q <= '0;
			s1_vld_q  <= 1'b0;
			s1_rep_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
				s1_rep_q <= (mode_t'(in_item.mode) == MODE_REPORT);
				if (mode_t'(in_item.mode) == MODE_STORE) begin
					pos_q <= (pos_q == AW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
				end
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (wr_en) begin
				row_vld_q[pos_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_s1 <= pos_q;
			for (int c = 0; c < CHANNELS; c++) begin
				smp_s1[c] <= fld[c];
			end
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		mwac_lane #(
			.WINDOW (WINDOW),
			.AW     (AW)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.rd_addr (pos_q),
			.row_vld (row_vld),
			.wr_en   (wr_en),
			.wr_addr (pos_s1),
			.wr_data (smp_s1[c]),
			.sum     (lane_sum[c])
		);
	end

	mwac_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.sums         (lane_sum),
		.ph_gain      (ph_gain_q),
		.ph_offset    (ph_ofs_q),
		.moist_gain   (moist_gain_q),
		.moist_offset (moist_ofs_q),
		.can_load     (can_load),
		.out_item     (out_item)
	);

endmodule

FILE: rtl/core/mwac_checker.sv
// Port-level checks of the window average calibrator and their binding.
module mwac_checker #(
	parameter int CHANNELS = mwac_pkg::CHANNELS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [mwac_pkg::CHAN_W-1:0]         out_channel,
	input logic signed [mwac_pkg::READING_W-1:0] out_reading,
	input logic                                out_last,
	input logic                                cfg_valid,
	input logic                                cfg_ready
);
	import mwac_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel)
			&& $stable(out_reading) && $stable(out_last))
		else $error("result changed while stalled");

	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_channel == CHAN_W'(CHANNELS - 1))))
		else $error("last flag does not match the final channel");

	// Results of one report leave back to back in channel order.
	a_chan_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid
			&& (out_channel == CHAN_W'($past(out_channel) + 1'b1)))
		else $error("report results out of sequence");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write not taken");

endmodule

bind multichannel_window_average_calibrate mwac_checker #(
	.CHANNELS (CHANNELS)
) u_mwac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_item.valid),
	.out_ready   (out_item.ready),
	.out_channel (out_item.channel),
	.out_reading (out_item.reading),
	.out_last    (out_item.last),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);

FILE: bench/tb_multichannel_window_average_calibrate.sv
// Self-checking testbench of the multichannel window average calibrator.
module tb_multichannel_window_average_calibrate;
	import mwac_pkg::*;

	typedef logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] sample_vec_t;

	typedef struct packed {
		mode_t       mode;
		logic        drain;
		sample_vec_t smp;
	} sample_set_t;

	typedef struct packed {
		logic [CHAN_W-1:0]           channel;
		logic signed [READING_W-1:0] reading;
		logic                        last;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mwac_in_if  in_if();
	mwac_out_if out_if();
	mwac_cfg_if cfg_if();

	multichannel_window_average_calibrate uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_if),
		.out_item (out_if),
		.cfg      (cfg_if)
	);

	// Shadow of the block: rings, window sums, write pointer and registers.
	logic [SAMPLE_W-1:0]     ring [CHANNELS_DEF][WINDOW_DEF];
	logic [SUM_W-1:0]        win_sum [CHANNELS_DEF];
	int unsigned             wr_pos;
	logic signed [GAIN_W-1:0] ph_gain_q    = PH_GAIN_RST;
	logic signed [OFS_W-1:0]  ph_ofs_q     = PH_OFS_RST;
	logic signed [GAIN_W-1:0] moist_gain_q = MOIST_GAIN_RST;
	logic signed [OFS_W-1:0]  moist_ofs_q  = MOIST_OFS_RST;

	sample_set_t pending_sets[$];
	reading_t    expected_readings[$];
	sample_set_t in_flight;
	int          in_gap;
	int          out_stall;
	int          error_count = 0;
	bit          idle_on = 1'b1;

	initial begin
		for (int c = 0; c < CHANNELS_DEF; c++) begin
			win_sum[c] = '0;
			for (int w = 0; w < WINDOW_DEF; w++)
				ring[c][w] = '0;
		end
		wr_pos = 0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The scaled product is floored by the arithmetic shift, then offset and clamped.
	function automatic logic signed [READING_W-1:0] calibrated_reading(
		input logic [SUM_W-1:0] sum,
		input logic signed [GAIN_W-1:0] gain,
		input logic signed [OFS_W-1:0] ofs
	);
		logic signed [63:0] prod;
		logic signed [63:0] r;
		prod = $signed({{(64 - SUM_W){1'b0}}, sum}) * $signed({{32{gain[GAIN_W-1]}}, gain});
		r = (prod >>> SCALE_SHIFT) + $signed({{48{ofs[OFS_W-1]}}, ofs});
		if (r > 64'sd32767)
			r = 64'sd32767;
		if (r < -64'sd32768)
			r = -64'sd32768;
		return r[READING_W-1:0];
	endfunction

	task automatic apply_sample_set(input sample_set_t it);
		reading_t exp_r;
		if (it.mode == MODE_STORE) begin
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				win_sum[c] = win_sum[c] - ring[c][wr_pos] + it.smp[c];
				ring[c][wr_pos] = it.smp[c];
			end
			wr_pos = (wr_pos + 1) % WINDOW_DEF;
		end else begin
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				exp_r.channel = CHAN_W'(c);
				if (c < PH_CHANNELS)
					exp_r.reading = calibrated_reading(win_sum[c], ph_gain_q, ph_ofs_q);
				else
					exp_r.reading = calibrated_reading(win_sum[c], moist_gain_q, moist_ofs_q);
				exp_r.last = (c == CHANNELS_DEF - 1);
				expected_readings.push_back(exp_r);
			end
		end
	endtask

	task automatic log_error(input string msg);
		if (error_count < 10)
			$display("%0t: %s", $time, msg);
		error_count++;
	endtask

	// Sample driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.mode <= MODE_STORE;
			in_if.ph_sample_a <= '0;
			in_if.ph_sample_b <= '0;
			in_if.ph_sample_c <= '0;
			in_if.ph_sample_d <= '0;
			in_if.wet_sample_a <= '0;
			in_if.wet_sample_b <= '0;
			in_if.wet_sample_c <= '0;
			in_if.wet_sample_d <= '0;
			in_gap <= 0;
		end else begin
			if (in_if.valid && in_if.ready)
				apply_sample_set(in_flight);
			if (!in_if.valid || in_if.ready) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_if.valid <= 1'b0;
				end else if (pending_sets.size() != 0 &&
						!(pending_sets[0].drain && expected_readings.size() != 0)) begin
					in_flight = pending_sets.pop_front();
					in_if.valid <= 1'b1;
					in_if.mode <= in_flight.mode;
					in_if.ph_sample_a <= in_flight.smp[0];
					in_if.ph_sample_b <= in_flight.smp[1];
					in_if.ph_sample_c <= in_flight.smp[2];
					in_if.ph_sample_d <= in_flight.smp[3];
					in_if.wet_sample_a <= in_flight.smp[4];
					in_if.wet_sample_b <= in_flight.smp[5];
					in_if.wet_sample_c <= in_flight.smp[6];
					in_if.wet_sample_d <= in_flight.smp[7];
					in_gap <= pick_gap();
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		reading_t exp_r;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (expected_readings.size() == 0) begin
					log_error($sformatf("unexpected result: channel %0d reading %0d last %0b",
						out_if.channel, out_if.reading, out_if.last));
				end else begin
					exp_r = expected_readings.pop_front();
					if (out_if.channel !== exp_r.channel || out_if.reading !== exp_r.reading ||
							out_if.last !== exp_r.last)
						log_error($sformatf(
							"mismatch: expected ch %0d rd %0d last %0b, got ch %0d rd %0d last %0b",
							exp_r.channel, exp_r.reading, exp_r.last,
							out_if.channel, out_if.reading, out_if.last));
				end
			end
			if (out_stall != 0) begin
				out_stall <= out_stall - 1;
				out_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 12) begin
				out_stall <= pick_gap();
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	function automatic sample_vec_t random_samples();
		sample_vec_t s;
		for (int c = 0; c < NUM_FIELDS; c++) begin
			case ($urandom_range(0, 7))
				0: s[c] = '0;
				1: s[c] = '1;
				2: s[c] = SAMPLE_W'($urandom_range(0, 15));
				default: s[c] = SAMPLE_W'($urandom_range(0, 4095));
			endcase
		end
		return s;
	endfunction

	task automatic queue_set(input mode_t m, input sample_vec_t s, input logic drain);
		sample_set_t it;
		it.mode = m;
		it.drain = drain;
		it.smp = s;
		pending_sets.push_back(it);
	endtask

	// Runs of stores closed by a report, now and then two reports back to back.
	task automatic queue_random(input int n_items);
		int left;
		int run;
		left = n_items;
		while (left > 0) begin
			run = $urandom_range(0, 12);
			for (int k = 0; k < run && left > 1; k++) begin
				queue_set(MODE_STORE, random_samples(), $urandom_range(0, 49) == 0);
				left--;
			end
			queue_set(MODE_REPORT, random_samples(), $urandom_range(0, 49) == 0);
			left--;
			if (left > 0 && $urandom_range(0, 4) == 0) begin
				queue_set(MODE_REPORT, random_samples(), 1'b0);
				left--;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_sets.size() != 0 || in_if.valid || expected_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d,
			input logic more);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= d;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_PH_GAIN:      ph_gain_q = d;
			CFG_PH_OFFSET:    ph_ofs_q = d[OFS_W-1:0];
			CFG_MOIST_GAIN:   moist_gain_q = d;
			CFG_MOIST_OFFSET: moist_ofs_q = d[OFS_W-1:0];
			default: ;
		endcase
		if (!more)
			cfg_if.valid <= 1'b0;
	endtask

	// Registers change only once the block has drained and settled.
	task automatic program_regs(input logic [31:0] pg, input logic [15:0] po,
			input logic [31:0] mg, input logic [15:0] mo);
		wait_idle();
		repeat (8) @(posedge clk);
		write_reg(CFG_PH_GAIN, pg, 1'b1);
		write_reg(CFG_PH_OFFSET, {{16{po[15]}}, po}, 1'b1);
		write_reg(CFG_MOIST_GAIN, mg, 1'b1);
		write_reg(CFG_MOIST_OFFSET, {{16{mo[15]}}, mo}, 1'b0);
	endtask

	initial begin
		sample_vec_t s;
		arst_n <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_PH_GAIN;
		cfg_if.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings. The first report sees only zeros, and
		// the store after it waits until that report has fully come out.
		queue_set(MODE_REPORT, '0, 1'b0);
		queue_set(MODE_STORE, '1, 1'b1);
		queue_set(MODE_STORE, '0, 1'b0);
		queue_set(MODE_STORE, {NUM_FIELDS{12'hAAA}}, 1'b0);
		queue_set(MODE_STORE, {NUM_FIELDS{12'h555}}, 1'b0);
		queue_set(MODE_REPORT, '1, 1'b0);
		for (int c = 0; c < NUM_FIELDS; c++)
			s[c] = SAMPLE_W'((c + 1) * 511);
		queue_set(MODE_STORE, s, 1'b0);
		for (int c = 0; c < NUM_FIELDS; c++)
			s[c] = c[0] ? 12'hFFF : 12'h000;
		queue_set(MODE_STORE, s, 1'b0);
		queue_set(MODE_REPORT, {NUM_FIELDS{12'h5A5}}, 1'b0);
		queue_set(MODE_REPORT, random_samples(), 1'b0);
		for (int k = 0; k < 8; k++)
			queue_set(MODE_STORE, random_samples(), 1'b0);
		queue_set(MODE_REPORT, random_samples(), 1'b0);
		queue_random(100);

		// Extreme gains and offsets, with a full window of maximum samples.
		program_regs(32'h7FFF_FFFF, 16'h7FFF, 32'h8000_0000, 16'h8000);
		for (int k = 0; k < WINDOW_DEF; k++)
			queue_set(MODE_STORE, '1, 1'b0);
		queue_set(MODE_REPORT, '0, 1'b0);
		queue_random(40);

		// Unit gains show the floor of a negative product; offsets at the rails.
		program_regs(32'hFFFF_FFFF, 16'h8000, 32'h0000_0001, 16'h7FFF);
		idle_on = 1'b0;
		queue_random(60);
		wait_idle();
		idle_on = 1'b1;

		// Gains in a range that keeps most readings unsaturated.
		program_regs(int'($urandom_range(0, 8000000)) - 4000000, 16'($urandom_range(0, 65535)),
			int'($urandom_range(0, 8000000)) - 4000000, 16'($urandom_range(0, 65535)));
		queue_random(80);

		program_regs($urandom, 16'($urandom_range(0, 65535)), $urandom,
			16'($urandom_range(0, 65535)));
		queue_random(80);

		program_regs(PH_GAIN_RST, PH_OFS_RST, MOIST_GAIN_RST, MOIST_OFS_RST);
		queue_random(40);

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_readings.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#6000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: multichannel_window_average_calibrate.f
rtl/core/mwac_pkg.sv
rtl/core/mwac_if.sv
rtl/core/mwac_lane.sv
rtl/core/mwac_merge.sv
rtl/core/multichannel_window_average_calibrate.sv
rtl/core/mwac_checker.sv
bench/tb_multichannel_window_average_calibrate.sv
